/* rtl/jstm_pkg.sv */
// ----------------------------------------------------------------------------
// JSON string matcher package
// Shared types, character codes and byte classifiers for the string matcher.
// ----------------------------------------------------------------------------
package jstm_pkg;

   // parse phase of the current string
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_BODY = 3'd1,
      PH_ESC  = 3'd2,
      PH_HEX  = 3'd3,
      PH_UTF  = 3'd4
   } phase_type;

   // control state carried from byte to byte
   typedef struct packed {
      phase_type  phase;
      logic       escape_seen;
      logic [2:0] bytes_expected;
      logic [2:0] seq_position;
      logic       fault_pending;
      logic [2:0] fault_offset;
   } ctrl_type;

   // one result word
   typedef struct packed {
      logic        status;
      logic        had_escape;
      logic [15:0] token_length;
   } result_type;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // character codes
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_B         = 8'h62;
   localparam logic [7:0] CH_F         = 8'h66;
   localparam logic [7:0] CH_N         = 8'h6E;
   localparam logic [7:0] CH_R         = 8'h72;
   localparam logic [7:0] CH_T         = 8'h74;
   localparam logic [7:0] CH_U         = 8'h75;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DEL       = 8'h7F;

   // number of bytes in a UTF-8 sequence from its lead byte, 0 if not a lead
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] n;
      unique case (b) inside
         [8'hC0:8'hDF]: n = 3'd2;
         [8'hE0:8'hEF]: n = 3'd3;
         [8'hF0:8'hF7]: n = 3'd4;
         [8'hF8:8'hFB]: n = 3'd5;
         [8'hFC:8'hFD]: n = 3'd6;
         default:       n = 3'd0;
      endcase
      return n;
   endfunction

   // letters allowed after a backslash, other than u
   function automatic logic simple_escape(input logic [7:0] b);
      return (b == CH_B) || (b == CH_F) || (b == CH_N) || (b == CH_R)
          || (b == CH_T) || (b == CH_BACKSLASH) || (b == CH_SLASH)
          || (b == CH_QUOTE);
   endfunction

   function automatic logic hex_digit(input logic [7:0] b);
      return ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h61) && (b <= 8'h66))
          || ((b >= 8'h41) && (b <= 8'h46));
   endfunction

endpackage

/* rtl/jstm_if.sv */
// ----------------------------------------------------------------------------
// JSON string matcher channels
// Valid/ready channels for input bytes, results and the mode register.
// ----------------------------------------------------------------------------

// input byte channel
interface jstm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       buffer_end;

   modport source (output valid, output data_byte, output first_byte,
                   output buffer_end, input ready);
   modport sink   (input valid, input data_byte, input first_byte,
                   input buffer_end, output ready);
endinterface

// result channel
interface jstm_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        had_escape;
   logic [15:0] token_length;

   modport source (output valid, output status, output had_escape,
                   output token_length, input ready);
   modport sink   (input valid, input status, input had_escape,
                   input token_length, output ready);
endinterface

// mode register write channel
interface jstm_csr_if;
   logic valid;
   logic ready;
   logic strict_mode;

   modport source (output valid, output strict_mode, input ready);
   modport sink   (input valid, input strict_mode, output ready);
endinterface

/* rtl/jstm_step.sv */
// ----------------------------------------------------------------------------
// JSON string matcher step logic
// Next state, length update and result for one byte of the string.
// ----------------------------------------------------------------------------
module jstm_step #(
   parameter int LENGTH_BITS = 16
) (
   input  jstm_pkg::ctrl_type      ctrl_cur,
   input  logic [LENGTH_BITS-1:0]  len_cur,
   input  logic [7:0]              data_byte,
   input  logic                    first_byte,
   input  logic                    buffer_end,
   input  logic                    strict_mode,
   output jstm_pkg::ctrl_type      ctrl_nxt,
   output logic [LENGTH_BITS-1:0]  len_nxt,
   output logic                    emit,
   output jstm_pkg::result_type    result
);

   // saturating add of a small amount
   function automatic logic [LENGTH_BITS-1:0] sat_add(
      input logic [LENGTH_BITS-1:0] a,
      input logic [2:0]             k
   );
      logic [LENGTH_BITS:0] s;
      s = {1'b0, a} + (LENGTH_BITS+1)'(k);
      return s[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : s[LENGTH_BITS-1:0];
   endfunction

   logic [2:0]                lead_n;
   logic                      cont_bad;
   logic                      fp_new;
   logic [2:0]                fo_new;
   logic [3:0]                seq_inc;
   logic [LENGTH_BITS-1:0]    len_one;
   logic [LENGTH_BITS-1:0]    len_two;
   logic [LENGTH_BITS-1:0]    len_four;
   logic [LENGTH_BITS-1:0]    len_seq;
   logic [LENGTH_BITS-1:0]    len_fault;
   logic [LENGTH_BITS-1:0]    res_len;
   logic                      res_status;
   logic [LENGTH_BITS+15:0]   res_wide;

   assign lead_n    = jstm_pkg::lead_length(data_byte);
   assign cont_bad  = !(data_byte[7] && !data_byte[6]);
   assign fp_new    = ctrl_cur.fault_pending || cont_bad;
   assign fo_new    = (cont_bad && !ctrl_cur.fault_pending) ? ctrl_cur.seq_position
                                                            : ctrl_cur.fault_offset;
   assign seq_inc   = {1'b0, ctrl_cur.seq_position} + 4'd1;
   assign len_one   = sat_add(len_cur, 3'd1);
   assign len_two   = sat_add(len_cur, 3'd2);
   assign len_four  = sat_add(len_cur, 3'd4);
   assign len_seq   = sat_add(len_cur, ctrl_cur.bytes_expected);
   assign len_fault = sat_add(len_cur, fo_new);

   // phase transitions
   always_comb begin
      ctrl_nxt   = ctrl_cur;
      len_nxt    = len_cur;
      emit       = 1'b0;
      res_status = jstm_pkg::STATUS_ERROR;
      res_len    = len_cur;

      if (first_byte) begin
         // opening quote, whatever the byte is
         ctrl_nxt.phase          = jstm_pkg::PH_BODY;
         ctrl_nxt.escape_seen    = 1'b0;
         ctrl_nxt.bytes_expected = 3'd0;
         ctrl_nxt.seq_position   = 3'd0;
         ctrl_nxt.fault_pending  = 1'b0;
         ctrl_nxt.fault_offset   = 3'd0;
         len_nxt                 = LENGTH_BITS'(1);
         res_len                 = LENGTH_BITS'(1);
         emit                    = buffer_end;
      end else begin
         unique case (ctrl_cur.phase)
            jstm_pkg::PH_BODY: begin
               if (data_byte == jstm_pkg::CH_QUOTE) begin
                  emit       = 1'b1;
                  res_status = jstm_pkg::STATUS_OK;
                  res_len    = len_one;
               end else if (data_byte == jstm_pkg::CH_BACKSLASH) begin
                  ctrl_nxt.escape_seen = 1'b1;
                  ctrl_nxt.phase       = jstm_pkg::PH_ESC;
                  emit                 = buffer_end;
               end else if (!data_byte[7]) begin
                  if (strict_mode && ((data_byte < jstm_pkg::CH_SPACE)
                                      || (data_byte == jstm_pkg::CH_DEL))) begin
                     emit = 1'b1;
                  end else begin
                     len_nxt = len_one;
                     res_len = len_one;
                     emit    = buffer_end;
                  end
               end else if ((lead_n == 3'd0) || buffer_end) begin
                  emit = 1'b1;
               end else begin
                  ctrl_nxt.bytes_expected = lead_n;
                  ctrl_nxt.seq_position   = 3'd1;
                  ctrl_nxt.fault_pending  = 1'b0;
                  ctrl_nxt.fault_offset   = 3'd0;
                  ctrl_nxt.phase          = jstm_pkg::PH_UTF;
               end
            end

            jstm_pkg::PH_ESC: begin
               if ((data_byte == jstm_pkg::CH_U) || jstm_pkg::simple_escape(data_byte)) begin
                  len_nxt = len_two;
                  res_len = len_two;
                  emit    = buffer_end;
                  ctrl_nxt.seq_position = 3'd0;
                  ctrl_nxt.phase = (data_byte == jstm_pkg::CH_U) ? jstm_pkg::PH_HEX
                                                                 : jstm_pkg::PH_BODY;
               end else begin
                  emit = 1'b1;
               end
            end

            jstm_pkg::PH_HEX: begin
               if (!jstm_pkg::hex_digit(data_byte) || buffer_end) begin
                  emit = 1'b1;
               end else if (seq_inc >= 4'd4) begin
                  len_nxt               = len_four;
                  ctrl_nxt.seq_position = 3'd0;
                  ctrl_nxt.phase        = jstm_pkg::PH_BODY;
               end else begin
                  ctrl_nxt.seq_position = seq_inc[2:0];
               end
            end

            jstm_pkg::PH_UTF: begin
               ctrl_nxt.fault_pending = fp_new;
               ctrl_nxt.fault_offset  = fo_new;
               if (seq_inc >= {1'b0, ctrl_cur.bytes_expected}) begin
                  // last byte of the sequence
                  if (fp_new) begin
                     emit    = 1'b1;
                     res_len = len_fault;
                  end else begin
                     len_nxt               = len_seq;
                     res_len               = len_seq;
                     emit                  = buffer_end;
                     ctrl_nxt.seq_position = 3'd0;
                     ctrl_nxt.phase        = jstm_pkg::PH_BODY;
                  end
               end else if (buffer_end) begin
                  emit = 1'b1;
               end else begin
                  ctrl_nxt.seq_position = seq_inc[2:0];
               end
            end

            default: begin
               // idle: bytes outside a string are dropped
               ctrl_nxt.phase = jstm_pkg::PH_IDLE;
            end
         endcase
      end

      if (emit) begin
         ctrl_nxt.phase = jstm_pkg::PH_IDLE;
      end
   end

   // result word, length cut to the port width
   assign res_wide            = (LENGTH_BITS+16)'(res_len);
   assign result.status       = res_status;
   assign result.had_escape   = (res_status == jstm_pkg::STATUS_OK) ? ctrl_cur.escape_seen
                                                                    : 1'b0;
   assign result.token_length = res_wide[15:0];

endmodule

/* rtl/json_string_token_matcher.sv */
// ----------------------------------------------------------------------------
// JSON string token matcher
// Checks a JSON string token byte by byte and reports one result per string.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one byte per word with first_byte marking the opening
//   quote and buffer_end marking the last byte of the buffer. rsp_bus gives
//   at most one word per string: status 0 with had_escape and the length
//   including both quotes, or status 1 with the error length. csr_bus writes
//   strict_mode, which rejects control bytes and DEL inside the string; it is
//   always ready. The user writes it only while no string is in flight; the
//   block itself does not enforce this. Result path: the byte that ends the
//   string passes the input register, then the result register, before its
//   result appears on rsp_bus. Throughput: one byte per cycle while rsp_bus
//   does not stall; the state update between the registers is combinational.
//   Reset clears the parse state to idle, strict_mode to 0 and both
//   registers to empty. When rsp_bus stalls with a result held, the input
//   register keeps its byte and req_bus ready drops once it is full; no
//   word is lost or repeated.
// ----------------------------------------------------------------------------
module json_string_token_matcher #(
   parameter int LENGTH_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   jstm_req_if.sink          req_bus,
   jstm_rsp_if.source        rsp_bus,
   jstm_csr_if.sink          csr_bus
);

   logic                    strict_ff;
   logic                    in_valid_ff;
   logic [7:0]              in_byte_ff;
   logic                    in_first_ff;
   logic                    in_last_ff;
   jstm_pkg::ctrl_type      ctrl_ff;
   jstm_pkg::ctrl_type      ctrl_in;
   logic [LENGTH_BITS-1:0]  len_ff;
   logic [LENGTH_BITS-1:0]  len_in;
   logic                    emit;
   jstm_pkg::result_type    result;
   logic                    out_valid_ff;
   jstm_pkg::result_type    out_ff;
   logic                    advance;

   // byte in the input register moves on when the result slot is free
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         strict_ff <= csr_bus.strict_mode;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff  <= req_bus.data_byte;
         in_first_ff <= req_bus.first_byte;
         in_last_ff  <= req_bus.buffer_end;
      end
   end

   jstm_step #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_step (
      .ctrl_cur    (ctrl_ff),
      .len_cur     (len_ff),
      .data_byte   (in_byte_ff),
      .first_byte  (in_first_ff),
      .buffer_end  (in_last_ff),
      .strict_mode (strict_ff),
      .ctrl_nxt    (ctrl_in),
      .len_nxt     (len_in),
      .emit        (emit),
      .result      (result)
   );

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '{phase: jstm_pkg::PH_IDLE, default: '0};
         len_ff  <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
         len_ff  <= len_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit;
      end else if (rsp_bus.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.status       = out_ff.status;
   assign rsp_bus.had_escape   = out_ff.had_escape;
   assign rsp_bus.token_length = out_ff.token_length;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string token matcher testbench
// Streams JSON string tokens into the matcher. A scoreboard predicts each
// result from its own model of the parser and compares every result word
// field by field. The run covers directed corner tokens, one long token,
// and random phases. These phases change the strict mode, the sender's
// gaps and the receiver's stalls.
// ----------------------------------------------------------------------------

// predicts one result word per string and checks the words that come out
class token_scoreboard;
   jstm_pkg::phase_type  phase;
   logic [15:0]          length_count;
   logic                 escape_seen;
   logic [2:0]           bytes_expected;
   logic [2:0]           seq_position;
   logic                 fault_pending;
   logic [2:0]           fault_offset;
   logic                 strict_mode;
   jstm_pkg::result_type expected_tokens[$];
   int unsigned          fail_count;

   function new();
      fail_count     = 0;
      strict_mode    = 1'b0;
      phase          = jstm_pkg::PH_IDLE;
      length_count   = '0;
      escape_seen    = 1'b0;
      bytes_expected = '0;
      seq_position   = '0;
      fault_pending  = 1'b0;
      fault_offset   = '0;
   endfunction

   function logic [15:0] sat_add(logic [15:0] a, logic [2:0] b);
      logic [16:0] s;
      s = {1'b0, a} + 17'(b);
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   // UTF-8 sequence length from the lead byte, 0 when not a lead
   function logic [2:0] utf8_span(logic [7:0] c);
      if ((c & 8'hE0) == 8'hC0) return 3'd2;
      if ((c & 8'hF0) == 8'hE0) return 3'd3;
      if ((c & 8'hF8) == 8'hF0) return 3'd4;
      if ((c & 8'hFC) == 8'hF8) return 3'd5;
      if ((c & 8'hFE) == 8'hFC) return 3'd6;
      return 3'd0;
   endfunction

   function logic is_escape_letter(logic [7:0] c);
      case (c)
         jstm_pkg::CH_B, jstm_pkg::CH_F, jstm_pkg::CH_N, jstm_pkg::CH_R,
         jstm_pkg::CH_T, jstm_pkg::CH_BACKSLASH, jstm_pkg::CH_SLASH,
         jstm_pkg::CH_QUOTE: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function logic is_hex(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function void flag(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   // queue the word for the string that ends here and go idle
   function void close_token(logic status, logic [15:0] len);
      jstm_pkg::result_type r;
      r.status       = status;
      r.had_escape   = (status == jstm_pkg::STATUS_OK) ? escape_seen : 1'b0;
      r.token_length = len;
      expected_tokens.push_back(r);
      phase = jstm_pkg::PH_IDLE;
   endfunction

   // advance the parse by one accepted byte
   function void take_byte(logic [7:0] b, logic first, logic last);
      logic [2:0] n;
      if (first) begin
         length_count   = 16'd1;
         escape_seen    = 1'b0;
         bytes_expected = '0;
         seq_position   = '0;
         fault_pending  = 1'b0;
         fault_offset   = '0;
         phase          = jstm_pkg::PH_BODY;
         if (last) close_token(jstm_pkg::STATUS_ERROR, length_count);
         return;
      end
      case (phase)
         jstm_pkg::PH_BODY: begin
            if (b == jstm_pkg::CH_QUOTE) begin
               close_token(jstm_pkg::STATUS_OK, sat_add(length_count, 3'd1));
            end else if (b == jstm_pkg::CH_BACKSLASH) begin
               escape_seen = 1'b1;
               if (last) close_token(jstm_pkg::STATUS_ERROR, length_count);
               else phase = jstm_pkg::PH_ESC;
            end else if (!b[7]) begin
               if (strict_mode && (b < jstm_pkg::CH_SPACE || b == jstm_pkg::CH_DEL)) begin
                  close_token(jstm_pkg::STATUS_ERROR, length_count);
               end else begin
                  length_count = sat_add(length_count, 3'd1);
                  if (last) close_token(jstm_pkg::STATUS_ERROR, length_count);
               end
            end else begin
               n = utf8_span(b);
               if (n == 3'd0 || last) begin
                  close_token(jstm_pkg::STATUS_ERROR, length_count);
               end else begin
                  bytes_expected = n;
                  seq_position   = 3'd1;
                  fault_pending  = 1'b0;
                  fault_offset   = '0;
                  phase          = jstm_pkg::PH_UTF;
               end
            end
         end
         jstm_pkg::PH_ESC: begin
            if (b == jstm_pkg::CH_U || is_escape_letter(b)) begin
               length_count = sat_add(length_count, 3'd2);
               if (last) close_token(jstm_pkg::STATUS_ERROR, length_count);
               else if (b == jstm_pkg::CH_U) begin
                  seq_position = '0;
                  phase        = jstm_pkg::PH_HEX;
               end else phase = jstm_pkg::PH_BODY;
            end else begin
               close_token(jstm_pkg::STATUS_ERROR, length_count);
            end
         end
         jstm_pkg::PH_HEX: begin
            if (!is_hex(b) || last) begin
               close_token(jstm_pkg::STATUS_ERROR, length_count);
            end else begin
               seq_position = seq_position + 3'd1;
               if (seq_position >= 3'd4) begin
                  length_count = sat_add(length_count, 3'd4);
                  seq_position = '0;
                  phase        = jstm_pkg::PH_BODY;
               end
            end
         end
         jstm_pkg::PH_UTF: begin
            // remember the first bad continuation, report at sequence end
            if (!(b[7] && !b[6]) && !fault_pending) begin
               fault_pending = 1'b1;
               fault_offset  = seq_position;
            end
            if ({1'b0, seq_position} + 4'd1 >= {1'b0, bytes_expected}) begin
               if (fault_pending) begin
                  close_token(jstm_pkg::STATUS_ERROR, sat_add(length_count, fault_offset));
               end else begin
                  length_count = sat_add(length_count, bytes_expected);
                  if (last) close_token(jstm_pkg::STATUS_ERROR, length_count);
                  else begin
                     seq_position = '0;
                     phase        = jstm_pkg::PH_BODY;
                  end
               end
            end else if (last) begin
               close_token(jstm_pkg::STATUS_ERROR, length_count);
            end else begin
               seq_position = seq_position + 3'd1;
            end
         end
         jstm_pkg::PH_IDLE: ;
         default: phase = jstm_pkg::PH_IDLE;
      endcase
   endfunction

   function void check_token(jstm_pkg::result_type got);
      jstm_pkg::result_type want;
      if (expected_tokens.size() == 0) begin
         flag($sformatf("unexpected result: status %0d esc %0d len %0d",
                        got.status, got.had_escape, got.token_length));
         return;
      end
      want = expected_tokens.pop_front();
      if (got.status != want.status || got.had_escape != want.had_escape
          || got.token_length != want.token_length)
         flag($sformatf({"mismatch: expected status %0d esc %0d len %0d,",
                         " got status %0d esc %0d len %0d"},
                        want.status, want.had_escape, want.token_length,
                        got.status, got.had_escape, got.token_length));
   endfunction

   function void check_drained();
      if (expected_tokens.size() != 0)
         flag($sformatf("%0d results never arrived", expected_tokens.size()));
   endfunction
endclass

module tb;

   // body element classes used by the token generator
   typedef enum {
      EL_PLAIN, EL_CONTROL, EL_ESCAPE, EL_UNICODE, EL_UTF8,
      EL_BAD_ESCAPE, EL_BAD_HEX, EL_BAD_CONT, EL_RAW
   } element_type;

   // how a generated token ends
   typedef enum {END_QUOTE, END_BUFFER, END_DROP} token_end_type;

   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int PHASE_BYTES   = 200;
   localparam int LONG_BYTES    = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   jstm_req_if req_bus();
   jstm_rsp_if rsp_bus();
   jstm_csr_if csr_bus();

   json_string_token_matcher #(.LENGTH_BITS(16)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   token_scoreboard sb;
   logic [7:0]      body_bytes[$];
   int              max_gap;
   int              stall_pct;
   int              burst_left;
   int              rsp_hold_req;
   logic            strict_now;

   // watch every handshake at the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) sb.strict_mode = csr_bus.strict_mode;
         if (req_bus.valid && req_bus.ready)
            sb.take_byte(req_bus.data_byte, req_bus.first_byte, req_bus.buffer_end);
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_token(jstm_pkg::result_type'({rsp_bus.status, rsp_bus.had_escape,
                                                   rsp_bus.token_length}));
      end
   end

   // receiver: random ready/stall runs, plus a long hold-off on request
   initial begin : receiver
      int   run_left;
      int   hold_left;
      logic ready_now;
      run_left  = 0;
      hold_left = 0;
      ready_now = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req > 0) begin
            hold_left    = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            run_left  = 0;
            ready_now = 1'b0;
         end else begin
            if (run_left == 0) begin
               ready_now = ($urandom_range(0, 99) >= stall_pct);
               run_left  = ready_now ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            run_left--;
         end
         rsp_bus.ready <= ready_now;
      end
   end

   // one input word; an idle gap opens when a burst runs out
   task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
      int gap;
      if (max_gap > 0 && burst_left == 0) begin
         gap = $urandom_range(1, max_gap);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= data;
      req_bus.first_byte <= first;
      req_bus.buffer_end <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic write_strict(input logic v);
      csr_bus.valid       <= 1'b1;
      csr_bus.strict_mode <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      strict_now = v;
   endtask

   // stop sending until every predicted word is out, then let the block settle
   task automatic drain_results();
      int guard;
      guard = 0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_tokens.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] hex_char();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return 8'(8'h30 + r);
      if (r < 16) return 8'(8'h61 + r - 10);
      return 8'(8'h41 + r - 16);
   endfunction

   function automatic logic [7:0] escape_char();
      case ($urandom_range(0, 7))
         0: return jstm_pkg::CH_B;
         1: return jstm_pkg::CH_F;
         2: return jstm_pkg::CH_N;
         3: return jstm_pkg::CH_R;
         4: return jstm_pkg::CH_T;
         5: return jstm_pkg::CH_BACKSLASH;
         6: return jstm_pkg::CH_SLASH;
         default: return jstm_pkg::CH_QUOTE;
      endcase
   endfunction

   // append one body element, well-formed unless noisy picks a broken one
   function automatic void add_element(input bit noisy);
      element_type kind;
      int          r;
      int          n;
      int          bad_at;
      logic [7:0]  c;
      r = noisy ? $urandom_range(0, 99) : $urandom_range(0, 69);
      if (r < 30) kind = EL_PLAIN;
      else if (r < 36) kind = (strict_now && !noisy) ? EL_PLAIN : EL_CONTROL;
      else if (r < 46) kind = EL_ESCAPE;
      else if (r < 54) kind = EL_UNICODE;
      else if (r < 70) kind = EL_UTF8;
      else if (r < 78) kind = EL_BAD_ESCAPE;
      else if (r < 86) kind = EL_BAD_HEX;
      else if (r < 93) kind = EL_BAD_CONT;
      else kind = EL_RAW;
      case (kind)
         EL_PLAIN: begin
            do c = 8'($urandom_range(8'h20, 8'h7E));
            while (c == jstm_pkg::CH_QUOTE || c == jstm_pkg::CH_BACKSLASH);
            body_bytes.push_back(c);
         end
         EL_CONTROL:
            body_bytes.push_back($urandom_range(0, 3) == 0 ? jstm_pkg::CH_DEL
                                                           : 8'($urandom_range(0, 31)));
         EL_ESCAPE: begin
            body_bytes.push_back(jstm_pkg::CH_BACKSLASH);
            body_bytes.push_back(escape_char());
         end
         EL_UNICODE: begin
            body_bytes.push_back(jstm_pkg::CH_BACKSLASH);
            body_bytes.push_back(jstm_pkg::CH_U);
            repeat (4) body_bytes.push_back(hex_char());
         end
         EL_UTF8, EL_BAD_CONT: begin
            n = $urandom_range(2, 6);
            case (n)
               2: body_bytes.push_back(8'(8'hC0 | $urandom_range(0, 31)));
               3: body_bytes.push_back(8'(8'hE0 | $urandom_range(0, 15)));
               4: body_bytes.push_back(8'(8'hF0 | $urandom_range(0, 7)));
               5: body_bytes.push_back(8'(8'hF8 | $urandom_range(0, 3)));
               default: body_bytes.push_back(8'(8'hFC | $urandom_range(0, 1)));
            endcase
            bad_at = (kind == EL_BAD_CONT) ? $urandom_range(1, n - 1) : 0;
            for (int i = 1; i < n; i++) begin
               if (i == bad_at || (bad_at != 0 && $urandom_range(0, 3) == 0)) begin
                  do c = 8'($urandom_range(0, 255)); while (c[7:6] == 2'b10);
               end else begin
                  c = 8'(8'h80 | $urandom_range(0, 63));
               end
               body_bytes.push_back(c);
            end
         end
         EL_BAD_ESCAPE: begin
            body_bytes.push_back(jstm_pkg::CH_BACKSLASH);
            do c = 8'($urandom_range(0, 255));
            while (c == jstm_pkg::CH_U || c == jstm_pkg::CH_B || c == jstm_pkg::CH_F
                   || c == jstm_pkg::CH_N || c == jstm_pkg::CH_R || c == jstm_pkg::CH_T
                   || c == jstm_pkg::CH_BACKSLASH || c == jstm_pkg::CH_SLASH
                   || c == jstm_pkg::CH_QUOTE);
            body_bytes.push_back(c);
         end
         EL_BAD_HEX: begin
            body_bytes.push_back(jstm_pkg::CH_BACKSLASH);
            body_bytes.push_back(jstm_pkg::CH_U);
            repeat ($urandom_range(0, 3)) body_bytes.push_back(hex_char());
            do c = 8'($urandom_range(0, 255));
            while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
            body_bytes.push_back(c);
         end
         default: body_bytes.push_back(8'($urandom_range(0, 255)));
      endcase
   endfunction

   // one random token; counts the token's words that it sends, not stray words
   task automatic send_token(input bit noisy, inout int sent);
      token_end_type ending;
      int            r;
      logic [7:0]    open_char;
      logic          last;
      body_bytes.delete();
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8))
         add_element(noisy);
      r = $urandom_range(0, 99);
      ending = (r < 75) ? END_QUOTE : (r < 87) ? END_BUFFER : END_DROP;
      if (ending == END_QUOTE) body_bytes.push_back(jstm_pkg::CH_QUOTE);
      open_char = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                               : jstm_pkg::CH_QUOTE;
      last = ($urandom_range(0, 49) == 0) || (ending == END_BUFFER && body_bytes.size() == 0);
      send_byte(open_char, 1'b1, last);
      sent++;
      foreach (body_bytes[i]) begin
         last = (ending == END_BUFFER && i == body_bytes.size() - 1)
                || ($urandom_range(0, 99) == 0);
         send_byte(body_bytes[i], 1'b0, last);
         sent++;
      end
      // the odd stray word between strings, normally ignored
      if ($urandom_range(0, 19) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
   endtask

   initial begin : stimulus
      // first, last, data of the directed words
      logic [9:0] directed[31];
      int         sent;
      directed = '{
         {2'b10, 8'h78}, {2'b00, 8'h5C}, {2'b00, 8'h75}, {2'b00, 8'h30},
         {2'b00, 8'h46}, {2'b00, 8'h61}, {2'b00, 8'h39}, {2'b00, 8'hFD},
         {2'b00, 8'h80}, {2'b00, 8'hBF}, {2'b00, 8'h80}, {2'b00, 8'h80},
         {2'b00, 8'h80}, {2'b00, 8'h00}, {2'b00, 8'h7F}, {2'b00, 8'h22},
         {2'b11, 8'h22},
         {2'b10, 8'h22}, {2'b00, 8'hE2}, {2'b00, 8'h41}, {2'b00, 8'h82},
         {2'b10, 8'h22}, {2'b00, 8'h5C}, {2'b00, 8'h71}, {2'b00, 8'h61},
         {2'b10, 8'h22}, {2'b00, 8'hFF},
         {2'b10, 8'h22}, {2'b01, 8'hC3},
         {2'b10, 8'h22}, {2'b00, 8'h1F}
      };
      sb           = new();
      max_gap      = 0;
      stall_pct    = 0;
      burst_left   = 0;
      rsp_hold_req = 0;
      strict_now   = 1'b0;
      req_bus.valid       <= 1'b0;
      req_bus.data_byte   <= '0;
      req_bus.first_byte  <= 1'b0;
      req_bus.buffer_end  <= 1'b0;
      csr_bus.valid       <= 1'b0;
      csr_bus.strict_mode <= 1'b0;
      reset               <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed corner tokens, the last one under strict mode
      write_strict(1'b0);
      for (int i = 0; i < 29; i++)
         send_byte(directed[i][7:0], directed[i][9], directed[i][8]);
      drain_results();
      write_strict(1'b1);
      for (int i = 29; i < 31; i++)
         send_byte(directed[i][7:0], directed[i][9], directed[i][8]);
      drain_results();

      // one long well-formed token, no idling anywhere
      write_strict(1'b0);
      sent = 0;
      send_byte(jstm_pkg::CH_QUOTE, 1'b1, 1'b0);
      while (sent < LONG_BYTES) begin
         body_bytes.delete();
         add_element(1'b0);
         foreach (body_bytes[i]) send_byte(body_bytes[i], 1'b0, 1'b0);
         sent += body_bytes.size();
      end
      send_byte(jstm_pkg::CH_QUOTE, 1'b0, 1'b0);
      drain_results();

      // random phases with changing mode and handshake pressure
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin max_gap = 0; stall_pct = 0;  end
            1: begin max_gap = 2; stall_pct = 30; end
            2: begin max_gap = 8; stall_pct = 60; end
            default: begin max_gap = 3; stall_pct = 10; end
         endcase
         burst_left = 0;
         write_strict(ph[0]);
         sent = 0;
         while (sent < PHASE_BYTES) begin
            send_token($urandom_range(0, 3) == 0, sent);
            if (ph == 3 && sent >= PHASE_BYTES / 2 && rsp_hold_req == 0 && max_gap != 0) begin
               // receiver holds off while the sender keeps pushing
               rsp_hold_req = 400;
               max_gap      = 0;
            end
            if (ph == 5 && sent >= PHASE_BYTES / 2 && stall_pct != 0) begin
               drain_results();
               stall_pct = 0;
            end
         end
         // a one-word string always ends any string in flight
         send_byte(jstm_pkg::CH_QUOTE, 1'b1, 1'b1);
         drain_results();
      end

      sb.check_drained();
      if (sb.fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/jstm_pkg.sv
rtl/jstm_if.sv
rtl/jstm_step.sv
rtl/json_string_token_matcher.sv
tb/sv/tb.sv
